// ----- hdl/fds_pkg.sv -----
// Shared types, constants and helpers of the fire diffusion stencil.
`timescale 1ns / 1ps
`default_nettype none

package fds_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT        = 1024;
   localparam int DIM_MIN           = 3;

   localparam int DIM_BITS   = 11;
   localparam int ROW_BITS   = 10;
   localparam int COORD_BITS = 10;
   localparam int NOISE_BITS = 10;
   localparam int CHAN_BITS  = 8;

   localparam logic [DIM_BITS-1:0] FRAME_DIM_RESET = 11'd1024;

   // csr word index (paddr[2])
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
   localparam int QPW         = $clog2(QUEUE_DEPTH);

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 48;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } pix_type;

   typedef struct packed {
      pix_type                prev;
      pix_type                older;
      logic [NOISE_BITS-1:0]  noise;
   } line_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]  dest_row;
      logic [COORD_BITS-1:0]  dest_col;
      pix_type                down;
      pix_type                up;
      pix_type                left;
      pix_type                right;
      logic [NOISE_BITS-1:0]  noise;
   } job_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] frame_width;
      logic [DIM_BITS-1:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } front_stat_type;

   typedef struct packed {
      logic [QCW-1:0] count;
      logic           not_empty;
   } queue_stat_type;

   // four-tap average minus noise, 1/16 fixed point, clamped at zero
   function automatic logic [CHAN_BITS-1:0] cool(
      input logic [CHAN_BITS-1:0]  a,
      input logic [CHAN_BITS-1:0]  b,
      input logic [CHAN_BITS-1:0]  c,
      input logic [CHAN_BITS-1:0]  d,
      input logic [NOISE_BITS-1:0] noise
   );
      logic [CHAN_BITS+1:0]  sum;
      logic [CHAN_BITS+3:0]  scaled;
      logic [CHAN_BITS+3:0]  nz;
      logic [CHAN_BITS+3:0]  diff;
      sum    = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
      scaled = {sum, 2'b00};
      nz     = {2'b00, noise};
      diff   = scaled - nz;
      if (scaled <= nz) begin
         cool = '0;
      end else begin
         cool = diff[CHAN_BITS+3:4];
      end
   endfunction

endpackage

`default_nettype wire

// ----- hdl/fire_diffusion_stencil.sv -----
// Top level of the fire diffusion stencil: registers, front, queue and back end.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake               Payload
// req_     in   req_tvalid/req_tready   one pixel and its cooling noise per transaction
// rsp_     out  rsp_tvalid/rsp_tready   one cooled pixel with destination coordinates
// csr_     in   APB psel/penable        frame_width (0x0), frame_height (0x4)
//
// Sustained rate is one pixel per clock; one read and one write of the line
// store per clock set it. A result passes from the read stage through the
// job queue into the back end's output register. After reset the line store
// is zeroed with req_tready low. A stall on rsp_ fills the four-entry job queue;
// req_tready drops once the queued jobs plus the pixel in the read stage reach
// four, so the queue never overflows.
module fire_diffusion_stencil #(
   parameter int MAX_WIDTH = fds_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // [7:0] red, [15:8] green, [23:16] blue, [33:24] heat_noise, rest zero
   input  wire logic [fds_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [9:0] dest_row, [19:10] dest_col, [27:20] out_red, [35:28] out_green,
   // [43:36] out_blue, rest zero
   output logic [fds_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [fds_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [fds_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [fds_pkg::CSR_DATA_BITS-1:0]         csr_prdata,
   output logic                                      csr_pready
);

   localparam int DW = fds_pkg::DIM_BITS;

   fds_pkg::cfg_type        cfg_ff;
   logic                    csr_write;
   fds_pkg::pix_type        in_pix;
   logic [fds_pkg::NOISE_BITS-1:0] in_noise;
   logic                    push_valid;
   fds_pkg::job_type        push_job;
   fds_pkg::job_type        head_job;
   fds_pkg::queue_stat_type qstat;
   fds_pkg::front_stat_type fstat;
   logic                    back_pop;

   // config: written on the access phase, always ready
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= fds_pkg::FRAME_DIM_RESET;
         cfg_ff.frame_height <= fds_pkg::FRAME_DIM_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            fds_pkg::CSR_IDX_WIDTH:  cfg_ff.frame_width  <= csr_pwdata[DW-1:0];
            fds_pkg::CSR_IDX_HEIGHT: cfg_ff.frame_height <= csr_pwdata[DW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         fds_pkg::CSR_IDX_WIDTH:
            csr_prdata = {{(fds_pkg::CSR_DATA_BITS-DW){1'b0}}, cfg_ff.frame_width};
         fds_pkg::CSR_IDX_HEIGHT:
            csr_prdata = {{(fds_pkg::CSR_DATA_BITS-DW){1'b0}}, cfg_ff.frame_height};
         default:
            csr_prdata = '0;
      endcase
   end

   // unpack the request transaction
   assign in_pix.red   = req_tdata[7:0];
   assign in_pix.green = req_tdata[15:8];
   assign in_pix.blue  = req_tdata[23:16];
   assign in_noise     = req_tdata[33:24];

   // counters, line store and tap window; issues one job per interior centre
   fds_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_pix     (in_pix),
      .in_noise   (in_noise),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_job   (push_job),
      .fstat      (fstat)
   );

   // decouples pixel intake from result back-pressure
   fds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (back_pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   // averaging, noise subtract, clamp and the output register
   fds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qstat.not_empty),
      .job       (head_job),
      .pop       (back_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

   // no pixel is taken while the line store is being zeroed
   assert property (@(posedge clock) disable iff (reset) fstat.clearing |-> !req_tready)
      else $error("pixel accepted during line store clear");

   // the intake credit check must keep the queue from overflowing
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (qstat.count < fds_pkg::QCW'(fds_pkg::QUEUE_DEPTH)))
      else $error("job pushed into a full queue");

   // a result appears only after a job was taken from the queue
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_tvalid) |-> $past(back_pop))
      else $error("result shown without a queued job");

endmodule

`default_nettype wire

// ----- hdl/fds_front.sv -----
// Front end: position counters, line store, tap window and job issue.
`timescale 1ns / 1ps
`default_nettype none

module fds_front #(
   parameter int MAX_WIDTH = fds_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire fds_pkg::cfg_type                   cfg,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire fds_pkg::pix_type                   in_pix,
   input  wire logic [fds_pkg::NOISE_BITS-1:0]     in_noise,
   input  wire fds_pkg::queue_stat_type            qstat,
   output logic                                    push_valid,
   output fds_pkg::job_type                        push_job,
   output fds_pkg::front_stat_type                 fstat
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WCMP = (CW + 1 > fds_pkg::DIM_BITS) ? CW + 1 : fds_pkg::DIM_BITS;
   localparam int RW   = fds_pkg::ROW_BITS;
   localparam int DW   = fds_pkg::DIM_BITS;

   // line store: previous row, older row and previous-row noise per column
   fds_pkg::line_type line_mem [MAX_WIDTH];
   fds_pkg::line_type rd_ff;

   logic          clearing_ff, clearing_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic                            s1_valid_ff;
   logic                            s1_emit_ff;
   fds_pkg::pix_type                s1_cur_ff;
   logic [fds_pkg::NOISE_BITS-1:0]  s1_noise_ff;
   logic [CW-1:0]                   s1_col_ff;
   logic [RW-1:0]                   s1_row_ff;

   fds_pkg::pix_type               win0_ff, win1_ff, win2_ff, older_tap_ff;
   logic [fds_pkg::NOISE_BITS-1:0] noise_tap_ff;

   logic [WCMP-1:0] fw_x, eff_w, c_next, dc;
   logic [DW-1:0]   eff_h, r_step, r_next;
   logic            wrap, accept, emit;
   logic [CW-1:0]   c_cur;
   logic [RW-1:0]   r_cur, dr;
   logic [fds_pkg::QCW:0] in_flight;

   logic              mem_we;
   logic [CW-1:0]     mem_waddr;
   fds_pkg::line_type mem_wdata;

   always_comb begin
      fw_x = WCMP'(cfg.frame_width);
      if (fw_x < WCMP'(fds_pkg::DIM_MIN)) begin
         eff_w = WCMP'(fds_pkg::DIM_MIN);
      end else if (fw_x > WCMP'(MAX_WIDTH)) begin
         eff_w = WCMP'(MAX_WIDTH);
      end else begin
         eff_w = fw_x;
      end
      if (cfg.frame_height < DW'(fds_pkg::DIM_MIN)) begin
         eff_h = DW'(fds_pkg::DIM_MIN);
      end else if (cfg.frame_height > DW'(fds_pkg::MAX_HEIGHT)) begin
         eff_h = DW'(fds_pkg::MAX_HEIGHT);
      end else begin
         eff_h = cfg.frame_height;
      end
   end

   assign in_flight = {1'b0, qstat.count} + (fds_pkg::QCW+1)'(s1_valid_ff);
   assign in_ready  = !clearing_ff && (in_flight < (fds_pkg::QCW+1)'(fds_pkg::QUEUE_DEPTH));
   assign accept    = in_valid && in_ready;
   assign fstat.clearing = clearing_ff;

   // position of the incoming pixel, wrapping before it is taken
   always_comb begin
      wrap   = WCMP'(col_ff) >= eff_w;
      c_cur  = wrap ? '0 : col_ff;
      r_step = wrap ? ({1'b0, row_ff} + DW'(1)) : {1'b0, row_ff};
      r_cur  = (r_step >= eff_h) ? '0 : r_step[RW-1:0];
      emit   = (r_cur >= RW'(2)) && (c_cur >= CW'(2));
      c_next = WCMP'(c_cur) + WCMP'(1);
      r_next = {1'b0, r_cur} + DW'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c_next >= eff_w) begin
            col_in = '0;
            row_in = (r_next >= eff_h) ? '0 : r_next[RW-1:0];
         end else begin
            col_in = c_next[CW-1:0];
            row_in = r_cur;
         end
      end
   end

   // zero the line store after reset, one column per cycle
   always_comb begin
      clr_in      = clr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_in = clr_ff + CW'(1);
         if (clr_ff == CW'(MAX_WIDTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ff      <= clr_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff  <= emit;
         s1_cur_ff   <= in_pix;
         s1_noise_ff <= in_noise;
         s1_col_ff   <= c_cur;
         s1_row_ff   <= r_cur;
      end
   end

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we          = s1_valid_ff;
         mem_waddr       = s1_col_ff;
         mem_wdata.prev  = s1_cur_ff;
         mem_wdata.older = rd_ff.prev;
         mem_wdata.noise = s1_noise_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
   end

   // consecutive pixels never share a column, so read and write never collide
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[c_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win2_ff      <= win1_ff;
         win1_ff      <= rd_ff.prev;
         win0_ff      <= s1_cur_ff;
         older_tap_ff <= rd_ff.older;
         noise_tap_ff <= rd_ff.noise;
      end
   end

   always_comb begin
      dc = WCMP'(s1_col_ff) - WCMP'(1);
      dr = s1_row_ff - RW'(2);
      push_valid        = s1_valid_ff && s1_emit_ff;
      push_job.dest_row = dr[fds_pkg::COORD_BITS-1:0];
      push_job.dest_col = dc[fds_pkg::COORD_BITS-1:0];
      push_job.down     = win0_ff;
      push_job.up       = older_tap_ff;
      push_job.left     = win2_ff;
      push_job.right    = rd_ff.prev;
      push_job.noise    = noise_tap_ff;
   end

endmodule

`default_nettype wire

// ----- hdl/fds_queue.sv -----
// Short job queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none

module fds_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire fds_pkg::job_type         push_job,
   input  wire logic                     pop,
   output fds_pkg::job_type              head_job,
   output fds_pkg::queue_stat_type       qstat
);

   localparam int QPW = fds_pkg::QPW;
   localparam int QCW = fds_pkg::QCW;

   fds_pkg::job_type slot_ff [fds_pkg::QUEUE_DEPTH];
   logic [QPW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCW-1:0]   count_ff, count_in;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QPW'(fds_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + QPW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == QPW'(fds_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + QPW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   assign head_job        = slot_ff[rd_ff];
   assign qstat.count     = count_ff;
   assign qstat.not_empty = (count_ff != '0);

endmodule

`default_nettype wire

// ----- hdl/fds_back.sv -----
// Back end: per-channel cooling arithmetic and the result register.
`timescale 1ns / 1ps
`default_nettype none

module fds_back (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  job_valid,
   input  wire fds_pkg::job_type                      job,
   output logic                                       pop,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [fds_pkg::RSP_DATA_BITS-1:0]          rsp_data
);

   logic                              rsp_valid_ff;
   logic [fds_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [fds_pkg::CHAN_BITS-1:0]     r_val, g_val, b_val;

   assign pop = job_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      r_val = fds_pkg::cool(job.down.red, job.up.red, job.left.red, job.right.red,
                            job.noise);
      g_val = fds_pkg::cool(job.down.green, job.up.green, job.left.green,
                            job.right.green, job.noise);
      b_val = fds_pkg::cool(job.down.blue, job.up.blue, job.left.blue, job.right.blue,
                            job.noise);
      rsp_data_in = {4'b0000, b_val, g_val, r_val, job.dest_col, job.dest_row};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the fire diffusion stencil: pixel stream in, cooled pixels out.
`timescale 1ns / 1ps

class fire_cooling_scoreboard;

   localparam int MAX_COLS = fds_pkg::DEFAULT_MAX_WIDTH;

   typedef struct {
      logic [fds_pkg::COORD_BITS-1:0] dest_row;
      logic [fds_pkg::COORD_BITS-1:0] dest_col;
      fds_pkg::pix_type               color;
   } cooled_pixel_type;

   // predictor copy of the block's registers and line stores
   logic [fds_pkg::DIM_BITS-1:0]   width_reg;
   logic [fds_pkg::DIM_BITS-1:0]   height_reg;
   fds_pkg::pix_type               prev_row [MAX_COLS];
   fds_pkg::pix_type               older_row [MAX_COLS];
   logic [fds_pkg::NOISE_BITS-1:0] prev_noise [MAX_COLS];
   fds_pkg::pix_type               below_tap;
   fds_pkg::pix_type               prev_tap;
   fds_pkg::pix_type               left_tap;
   fds_pkg::pix_type               older_tap;
   logic [fds_pkg::NOISE_BITS-1:0] noise_tap;
   int unsigned                    col;
   int unsigned                    row;

   cooled_pixel_type               cooled_pixels_due [$];
   int                             failures;

   function new();
      width_reg  = fds_pkg::FRAME_DIM_RESET;
      height_reg = fds_pkg::FRAME_DIM_RESET;
      foreach (prev_row[i]) begin
         prev_row[i]   = '0;
         older_row[i]  = '0;
         prev_noise[i] = '0;
      end
      below_tap = '0;
      prev_tap  = '0;
      left_tap  = '0;
      older_tap = '0;
      noise_tap = '0;
      col       = 0;
      row       = 0;
      failures  = 0;
   endfunction

   function void write_register(input logic [fds_pkg::CSR_ADDR_BITS-1:0] addr,
                                input logic [fds_pkg::CSR_DATA_BITS-1:0] value);
      if (addr[2] == fds_pkg::CSR_IDX_WIDTH) begin
         width_reg = value[fds_pkg::DIM_BITS-1:0];
      end else begin
         height_reg = value[fds_pkg::DIM_BITS-1:0];
      end
   endfunction

   function int unsigned clamp_dim(input logic [fds_pkg::DIM_BITS-1:0] dim,
                                   input int unsigned top);
      if (dim < fds_pkg::DIM_MIN) begin
         return fds_pkg::DIM_MIN;
      end
      if (dim > top) begin
         return top;
      end
      return dim;
   endfunction

   // 4 * (sum of taps) in 1/16 units, minus noise, clamp at zero, drop fraction
   function logic [7:0] cool_channel(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c, input logic [7:0] d,
                                     input logic [fds_pkg::NOISE_BITS-1:0] noise);
      int unsigned scaled;
      scaled = 4 * (int'(a) + int'(b) + int'(c) + int'(d));
      if (scaled <= noise) begin
         return 8'd0;
      end
      return 8'((scaled - noise) >> 4);
   endfunction

   function void note_pixel(input logic [fds_pkg::REQ_DATA_BITS-1:0] data);
      fds_pkg::pix_type               cur;
      fds_pkg::pix_type               above;
      fds_pkg::pix_type               older;
      logic [fds_pkg::NOISE_BITS-1:0] nz;
      logic [fds_pkg::NOISE_BITS-1:0] pnoise;
      cooled_pixel_type               due;
      int unsigned                    w;
      int unsigned                    h;
      cur.red   = data[7:0];
      cur.green = data[15:8];
      cur.blue  = data[23:16];
      nz        = data[33:24];
      w = clamp_dim(width_reg, MAX_COLS);
      h = clamp_dim(height_reg, fds_pkg::MAX_HEIGHT);
      // a size change can leave the counters out of bounds
      if (col >= w) begin
         col = 0;
         row++;
      end
      if (row >= h) begin
         row = 0;
      end
      above  = prev_row[col];
      older  = older_row[col];
      pnoise = prev_noise[col];
      if (row >= 2 && col >= 2) begin
         due.dest_row    = 10'(row - 2);
         due.dest_col    = 10'(col - 1);
         due.color.red   = cool_channel(below_tap.red, older_tap.red, left_tap.red,
                                        above.red, noise_tap);
         due.color.green = cool_channel(below_tap.green, older_tap.green, left_tap.green,
                                        above.green, noise_tap);
         due.color.blue  = cool_channel(below_tap.blue, older_tap.blue, left_tap.blue,
                                        above.blue, noise_tap);
         cooled_pixels_due = {cooled_pixels_due, due};
      end
      older_row[col]  = above;
      prev_row[col]   = cur;
      prev_noise[col] = nz;
      left_tap  = prev_tap;
      prev_tap  = above;
      below_tap = cur;
      older_tap = older;
      noise_tap = pnoise;
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) begin
            row = 0;
         end
      end
   endfunction

   function void compare_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   function void check_result(input logic [fds_pkg::RSP_DATA_BITS-1:0] data);
      cooled_pixel_type due;
      if (cooled_pixels_due.size() == 0) begin
         $error("unexpected result transaction: tdata %h", data);
         failures++;
         return;
      end
      due = cooled_pixels_due.pop_front();
      compare_field("dest_row", due.dest_row, data[9:0]);
      compare_field("dest_col", due.dest_col, data[19:10]);
      compare_field("out_red", due.color.red, data[27:20]);
      compare_field("out_green", due.color.green, data[35:28]);
      compare_field("out_blue", due.color.blue, data[43:36]);
   endfunction

   function int pending();
      return cooled_pixels_due.size();
   endfunction

   function void check_leftovers();
      if (cooled_pixels_due.size() != 0) begin
         $error("%0d expected results never arrived", cooled_pixels_due.size());
         failures++;
      end
   endfunction

endclass

module testbench;

   import fds_pkg::*;

   // register byte addresses on the csr_ port
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_FRAME_WIDTH  = 3'h0;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_FRAME_HEIGHT = 3'h4;

   localparam int RANDOM_ITEMS   = 400;
   localparam int CALM_ITEMS     = 64;
   // results pass through the read stage, the job queue and the output register; leave some margin
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLD_OFF_CYCLES = 250;

   logic                      clock;
   logic                      reset;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   fire_cooling_scoreboard    sb;

   // set for the closing stretch: no idling on either side
   bit                        calm;
   // long receiver hold-offs asked by the stimulus, served by the sink
   int                        hold_requests;

   fire_diffusion_stencil dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      sb = new();
   end

   // Monitors sample at the rising edge; all drivers move on the falling edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.note_pixel(req_tdata);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
      end
   end

   // Result sink: random stall bursts, plus long hold-offs on request so the
   // job queue fills and the block pushes back on req_.
   initial begin : result_sink
      int burst;
      int holds_served;
      burst        = 0;
      holds_served = 0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (burst > 0) begin
            rsp_tready <= 1'b0;
            burst--;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            burst = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("testbench failed");
      $finish;
   end

   // Both APB phases; the register takes the value at the access edge.
   // The bus goes idle before the task returns, so back-to-back writes get a fresh setup phase.
   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_register(addr, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Offer one pixel and hold it until the transaction completes.
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic [NOISE_BITS-1:0] noise);
      req_tdata  <= {6'd0, noise, blue, green, red};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly in range, sometimes above it so the clamp does the work
   function automatic logic [NOISE_BITS-1:0] pick_noise();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 10'($urandom_range(641, 1023));
         default: return 10'($urandom_range(0, 640));
      endcase
   endfunction

   function automatic logic [DIM_BITS-1:0] pick_width();
      case ($urandom_range(0, 9))
         0: return 11'($urandom_range(0, 2));
         1: return 11'($urandom_range(1024, 2047));
         default: return 11'($urandom_range(3, 12));
      endcase
   endfunction

   function automatic logic [DIM_BITS-1:0] pick_height();
      case ($urandom_range(0, 9))
         0: return 11'($urandom_range(0, 2));
         1: return 11'($urandom_range(1024, 2047));
         default: return 11'($urandom_range(3, 8));
      endcase
   endfunction

   // Stop offering and wait for every expected result; optionally let the
   // pipeline settle too, since the last pixels may still be in flight.
   task automatic drain(input bit settle);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      if (settle) begin
         repeat (SETTLE_CYCLES) @(negedge clock);
      end
   endtask

   task automatic send_random_run(input int count, input bit pause_mid);
      int i;
      for (i = 0; i < count; i++) begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_noise());
         if (pause_mid && i == count / 2) begin
            drain(1'b0);
         end
      end
   endtask

   initial begin : stimulus
      int i;
      int phase;
      int sent_random;
      int run_len;
      calm          = 1'b0;
      hold_requests = 0;
      reset       = 1'b1;
      req_tdata   = '0;
      req_tvalid  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // line store clearing pass runs first with req_tready low
      do @(posedge clock); while (!req_tready);
      @(negedge clock);

      // Directed: sizes below the minimum act as a 3x3 frame, one interior
      // centre per frame.
      write_csr(ADDR_FRAME_WIDTH, 32'd0);
      write_csr(ADDR_FRAME_HEIGHT, 32'd1);
      // hottest taps, no cooling: full-scale result
      for (i = 0; i < 9; i++) begin
         send_pixel(8'd255, 8'd255, 8'd255, 10'd0);
      end
      // noise exactly equal to the scaled sum on green, below it on red
      for (i = 0; i < 9; i++) begin
         send_pixel(8'd255, 8'd50, 8'd0, 10'd800);
      end
      // cold frame under maximum noise clamps at zero
      for (i = 0; i < 9; i++) begin
         send_pixel(8'd0, 8'd0, 8'd0, 10'd1023);
      end
      drain(1'b1);

      // Random phases; size changes land mid-frame and wrap the counters.
      sent_random = 0;
      phase       = 0;
      while (sent_random < RANDOM_ITEMS) begin
         if (phase == 0) begin
            // small frame, many results: the long hold-off backs up the queue
            write_csr(ADDR_FRAME_WIDTH, 32'd5);
            write_csr(ADDR_FRAME_HEIGHT, 32'd6);
            hold_requests++;
         end else begin
            case ($urandom_range(0, 2))
               0: write_csr(ADDR_FRAME_WIDTH, {21'd0, pick_width()});
               1: write_csr(ADDR_FRAME_HEIGHT, {21'd0, pick_height()});
               default: begin
                  write_csr(ADDR_FRAME_WIDTH, {21'd0, pick_width()});
                  write_csr(ADDR_FRAME_HEIGHT, {21'd0, pick_height()});
               end
            endcase
         end
         run_len = $urandom_range(30, 90);
         send_random_run(run_len, phase == 1 || $urandom_range(0, 3) == 0);
         sent_random += run_len;
         drain(1'b1);
         phase++;
      end

      // Closing stretch, no idling: a height above the maximum acts as 1024.
      calm = 1'b1;
      write_csr(ADDR_FRAME_WIDTH, 32'd7);
      write_csr(ADDR_FRAME_HEIGHT, 32'd2047);
      send_random_run(CALM_ITEMS, 1'b0);
      drain(1'b1);

      sb.check_leftovers();
      if (sb.failures == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
